FILE: sv/fcs_pkg.sv
package fcs_pkg;

   // Default fixed-point fraction width of the fine clock, the averages and the wall delta.
   localparam int FRAC_BITS_DEF = 16;

   localparam int SCENE_W = 31;
   localparam int DELTA_W = 32;
   localparam int FINE_W  = 48;
   localparam int WALL_W  = 64;
   localparam int AVG_W   = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_FREQ   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_ENABLE = 1'd1;

   localparam logic [CSR_DATA_W-1:0] WALL_FREQ_RST = 32'd1000000000;

   // Shared divider geometry.
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 7;

   typedef struct packed {
      logic load;
      logic front;
      logic branch;
      logic ema;
      logic advance;
      logic offset;
      logic trim;
      logic commit;
   } fcs_cmd_type;

   typedef struct packed {
      logic smooth_ok;
      logic need_rate;
      logic div_done;
   } fcs_status_type;

endpackage

FILE: sv/fcs_divider.sv
module fcs_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [fcs_pkg::DIV_NUM_W-1:0]    num,
   input  logic [fcs_pkg::DIV_DEN_W-1:0]    den,
   input  logic [fcs_pkg::DIV_CNT_W-1:0]    iters,
   output logic [fcs_pkg::DIV_NUM_W-1:0]    quo,
   output logic                             done
);

   logic [fcs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [fcs_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [fcs_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [fcs_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [fcs_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [fcs_pkg::DIV_DEN_W:0]   shifted;
   logic                          ge;

   // One quotient bit per cycle, numerator bits enter from the top.
   always_comb begin
      shifted = {rem_ff, num_ff[fcs_pkg::DIV_NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in = iters;
         rem_in = '0;
         den_in = den;
         num_in = num;
         quo_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == fcs_pkg::DIV_CNT_W'(1));
         rem_in  = ge ? fcs_pkg::DIV_DEN_W'(shifted - {1'b0, den_ff})
                      : fcs_pkg::DIV_DEN_W'(shifted);
         num_in  = {num_ff[fcs_pkg::DIV_NUM_W-2:0], 1'b0};
         quo_in  = {quo_ff[fcs_pkg::DIV_NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

FILE: sv/fcs_datapath.sv
module fcs_datapath #(
   parameter int FRAC_BITS = fcs_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fcs_pkg::fcs_cmd_type                 cmd,
   output fcs_pkg::fcs_status_type              status,
   input  logic [fcs_pkg::CSR_DATA_W-1:0]       wall_freq,
   input  logic                                 fine_enable,
   input  logic [fcs_pkg::SCENE_W-1:0]          req_coarse_now,
   input  logic [fcs_pkg::WALL_W-1:0]           req_wall_now,
   input  logic                                 req_key_pause,
   input  logic                                 req_key_resume,
   input  logic                                 req_key_forward,
   input  logic                                 req_key_rewind,
   output logic [fcs_pkg::SCENE_W-1:0]          res_scene_time,
   output logic signed [fcs_pkg::DELTA_W-1:0]   res_frame_delta,
   output logic signed [fcs_pkg::FINE_W-1:0]    res_fine_time,
   output logic                                 res_override_coarse,
   output logic                                 res_paused
);

   localparam int DW_W   = FRAC_BITS + 6;
   localparam int RATE_W = 18;
   localparam int PROD_W = DW_W + RATE_W;
   localparam int ST_W   = 38;
   localparam int OFF_W  = 58;
   localparam logic [13:0] C_ALPHA = 14'd3277;
   localparam logic [13:0] C_SOFT  = 14'd655;
   localparam logic [13:0] C_FIRM  = 14'd6554;
   localparam logic [RATE_W-1:0] RATE_MIN = 18'd13107;
   localparam logic [RATE_W-1:0] RATE_MAX = 18'd196608;
   localparam logic [RATE_W-1:0] RATE_ONE = 18'd65536;
   localparam logic [fcs_pkg::AVG_W-1:0] RATE_THR = 32'((1 << FRAC_BITS) / 1000);
   localparam logic signed [OFF_W-1:0] OFF_SNAP = OFF_W'(120) << FRAC_BITS;
   localparam logic signed [OFF_W-1:0] OFF_FIRM = OFF_W'(8) << FRAC_BITS;
   localparam logic signed [ST_W-1:0]  SCENE_MAX = ST_W'(2147483647);

   function automatic logic [31:0] ema(input logic [31:0] avg, input logic [31:0] x);
      logic signed [32:0] d;
      logic signed [46:0] p;
      logic signed [34:0] r;
      d = $signed({1'b0, x}) - $signed({1'b0, avg});
      p = d * $signed({1'b0, C_ALPHA});
      r = $signed({3'b0, avg}) + 35'(p >>> 16);
      if (r < 0)
         return '0;
      else if (r > $signed({3'b0, 32'hFFFF_FFFF}))
         return 32'hFFFF_FFFF;
      else
         return r[31:0];
   endfunction

   // Item registers.
   logic [fcs_pkg::SCENE_W-1:0] now_ff;
   logic [fcs_pkg::WALL_W-1:0]  wall_ff;
   logic [3:0]                  keys_ff;

   // Architectural state.
   logic [fcs_pkg::SCENE_W-1:0] scene_ff;
   logic                        pause_ff;
   logic [fcs_pkg::FINE_W-1:0]  fine_ff;
   logic [fcs_pkg::AVG_W-1:0]   cavg_ff;
   logic [fcs_pkg::AVG_W-1:0]   wavg_ff;
   logic [fcs_pkg::WALL_W-1:0]  prev_wall_ff;

   // Work registers.
   logic signed [fcs_pkg::DELTA_W-1:0] delta_ff;
   logic [fcs_pkg::SCENE_W-1:0] st_ff;
   logic                        scrub_ff;
   logic                        smooth_ff;
   logic [fcs_pkg::WALL_W-1:0]  diff_ff;
   logic [5:0]                  dtim_ff;
   logic [DW_W-1:0]             dw_ff;
   logic                        rate_div_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic [fcs_pkg::FINE_W-1:0]  fadv_ff;
   logic signed [OFF_W-1:0]     off_ff;

   // Front-end logic.
   logic signed [32:0]     delta_raw, delta_cap;
   logic                   pause_new;
   logic signed [ST_W-1:0] base, step, s1, s2, st_sat;
   logic                   smooth;

   always_comb begin
      delta_raw = $signed({2'b0, now_ff}) - $signed({2'b0, scene_ff});
      delta_cap = (delta_raw > 33'sd300) ? 33'sd300 : delta_raw;
      pause_new = keys_ff[1] ? 1'b0 : (keys_ff[0] ? 1'b1 : pause_ff);
      base = pause_new ? $signed({7'b0, scene_ff}) : $signed({7'b0, now_ff});
      step = pause_new ? ST_W'(10) : (ST_W'(delta_cap) <<< 3);
      s1   = keys_ff[2] ? base + step : base;
      s2   = keys_ff[3] ? ((step > s1) ? '0 : s1 - step) : s1;
      if (s2 < 0)
         st_sat = '0;
      else if (s2 > SCENE_MAX)
         st_sat = SCENE_MAX;
      else
         st_sat = s2;
      smooth = fine_enable && !pause_new && !(keys_ff[2] || keys_ff[3])
               && !fine_ff[fcs_pkg::FINE_W-1] && (prev_wall_ff != '0);
   end

   // Hitch check.
   logic signed [31:0]   dtim;
   logic [31:0]          freq;
   logic [38:0]          diff100, diff_lim;
   logic                 ok;
   logic [63:0]          target;

   always_comb begin
      dtim     = $signed({1'b0, st_ff}) - $signed({1'b0, scene_ff});
      freq     = (wall_freq == '0) ? 32'd1 : wall_freq;
      diff100  = 39'(diff_ff[31:0]) * 39'd100;
      diff_lim = 39'(freq) * 39'd60;
      ok = (diff_ff != '0) && (diff_ff[63:32] == '0) && (diff100 <= diff_lim)
           && (dtim >= 0) && (dtim <= 32'sd60);
      target = 64'(st_ff) << FRAC_BITS;
   end

   // Averages and the divider requests for the wall delta and rate passes.
   logic [fcs_pkg::DIV_NUM_W-1:0] div_quo;
   logic                          div_done, div_start;
   logic [fcs_pkg::DIV_NUM_W-1:0] div_num;
   logic [fcs_pkg::DIV_DEN_W-1:0] div_den;
   logic [fcs_pkg::DIV_CNT_W-1:0] div_iters;
   logic [fcs_pkg::AVG_W-1:0]     cavg_new, wavg_new;
   logic                          need_rate;

   always_comb begin
      cavg_new  = ema(cavg_ff, 32'(dtim_ff) << FRAC_BITS);
      wavg_new  = ema(wavg_ff, 32'(div_quo[DW_W-1:0]));
      need_rate = wavg_new > RATE_THR;
      div_start = (cmd.branch && smooth_ff && ok) || (cmd.ema && need_rate);
      if (cmd.branch) begin
         div_num   = 64'(diff100) << FRAC_BITS;
         div_den   = freq;
         div_iters = 7'd64;
      end else begin
         div_num   = {cavg_new, 32'b0};
         div_den   = wavg_new;
         div_iters = 7'd48;
      end
   end

   fcs_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .quo   (div_quo),
      .done  (div_done)
   );

   // Advance and anchor.
   logic [RATE_W-1:0]          rate;
   logic [49:0]                fadv;
   logic signed [OFF_W-1:0]    off;
   logic                       big;
   logic [13:0]                coef;
   logic signed [47:0]         mulv;

   always_comb begin
      if (!rate_div_ff)
         rate = RATE_ONE;
      else if (div_quo < 64'(RATE_MIN))
         rate = RATE_MIN;
      else if (div_quo > 64'(RATE_MAX))
         rate = RATE_MAX;
      else
         rate = div_quo[RATE_W-1:0];
      fadv = 50'(fine_ff) + 50'(prod_ff >> 16);
      off  = $signed(OFF_W'(target)) - $signed(OFF_W'(fadv));
      big  = (off_ff > OFF_SNAP) || (off_ff < -OFF_SNAP);
      coef = ((off_ff > OFF_FIRM) || (off_ff < -OFF_FIRM)) ? C_FIRM : C_SOFT;
      mulv = $signed(off_ff[32:0]) * $signed({1'b0, coef});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scene_ff     <= '0;
         pause_ff     <= 1'b0;
         fine_ff      <= '1;
         cavg_ff      <= '0;
         wavg_ff      <= '0;
         prev_wall_ff <= '0;
      end else begin
         if (cmd.front)
            pause_ff <= pause_new;
         if (cmd.branch && !smooth_ff)
            fine_ff <= target[fcs_pkg::FINE_W-1:0];
         else if (cmd.branch && !ok && dtim > 0)
            fine_ff <= fine_ff + 48'(64'(dtim[30:0]) << FRAC_BITS);
         else if (cmd.trim)
            fine_ff <= big ? target[fcs_pkg::FINE_W-1:0]
                           : fadv_ff + 48'(mulv >>> 16);
         if (cmd.ema) begin
            cavg_ff <= cavg_new;
            wavg_ff <= wavg_new;
         end
         if (cmd.commit) begin
            scene_ff     <= st_ff;
            prev_wall_ff <= wall_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff  <= req_coarse_now;
         wall_ff <= req_wall_now;
         keys_ff <= {req_key_rewind, req_key_forward, req_key_resume, req_key_pause};
      end
      if (cmd.front) begin
         delta_ff  <= delta_cap[31:0];
         st_ff     <= st_sat[fcs_pkg::SCENE_W-1:0];
         scrub_ff  <= keys_ff[2] || keys_ff[3];
         smooth_ff <= smooth;
         diff_ff   <= wall_ff - prev_wall_ff;
      end
      if (cmd.branch)
         dtim_ff <= dtim[5:0];
      if (cmd.ema) begin
         dw_ff       <= div_quo[DW_W-1:0];
         rate_div_ff <= need_rate;
      end
      if (cmd.advance)
         prod_ff <= PROD_W'(dw_ff) * PROD_W'(rate);
      if (cmd.offset) begin
         fadv_ff <= fadv[fcs_pkg::FINE_W-1:0];
         off_ff  <= off;
      end
   end

   assign status.smooth_ok = smooth_ff && ok;
   assign status.need_rate = need_rate;
   assign status.div_done  = div_done;

   assign res_scene_time      = st_ff;
   assign res_frame_delta     = delta_ff;
   assign res_fine_time       = $signed(fine_ff);
   assign res_override_coarse = pause_ff || scrub_ff;
   assign res_paused          = pause_ff;

endmodule

FILE: sv/fcs_ctrl.sv
module fcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_free,
   input  fcs_pkg::fcs_status_type status,
   output fcs_pkg::fcs_cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_FRONT    = 10'b0000000010,
      S_BRANCH   = 10'b0000000100,
      S_DW_RUN   = 10'b0000001000,
      S_EMA      = 10'b0000010000,
      S_RATE_RUN = 10'b0000100000,
      S_ADVANCE  = 10'b0001000000,
      S_OFFSET   = 10'b0010000000,
      S_TRIM     = 10'b0100000000,
      S_COMMIT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_FRONT;
         S_FRONT:    state_in = S_BRANCH;
         S_BRANCH:   state_in = status.smooth_ok ? S_DW_RUN : S_COMMIT;
         S_DW_RUN:   if (status.div_done) state_in = S_EMA;
         S_EMA:      state_in = status.need_rate ? S_RATE_RUN : S_ADVANCE;
         S_RATE_RUN: if (status.div_done) state_in = S_ADVANCE;
         S_ADVANCE:  state_in = S_OFFSET;
         S_OFFSET:   state_in = S_TRIM;
         S_TRIM:     state_in = S_COMMIT;
         S_COMMIT:   if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.load    = (state_ff == S_IDLE) && req_valid;
   assign cmd.front   = (state_ff == S_FRONT);
   assign cmd.branch  = (state_ff == S_BRANCH);
   assign cmd.ema     = (state_ff == S_EMA);
   assign cmd.advance = (state_ff == S_ADVANCE);
   assign cmd.offset  = (state_ff == S_OFFSET);
   assign cmd.trim    = (state_ff == S_TRIM);
   assign cmd.commit  = (state_ff == S_COMMIT) && rsp_free;

endmodule

FILE: sv/frame_clock_smoother_top.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   coarse_now, wall_now, four keys
// rsp       out        rsp_valid / rsp_ready   scene_time, frame_delta, fine_time, flags
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// An item on the smoothing path runs from its acceptance to the next acceptance
// through the wall delta pass of the shared bit-serial divider, the rate ratio
// pass and eight control steps. When the wall average is too small for the
// ratio, that pass is skipped. Paused, scrubbed, hitched or unsmoothed items go
// from the branch step straight to the commit step. Reset is
// synchronous and active high; it restores the register defaults and marks the
// fine clock invalid. A result waits in the output register while the next item
// is already being taken in; if it still waits when the next one is finished, the
// controller holds in its commit step and the input stays closed.
module frame_clock_smoother_top #(
   parameter int FRAC_BITS = fcs_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fcs_pkg::SCENE_W-1:0]          req_coarse_now,
   input  logic [fcs_pkg::WALL_W-1:0]           req_wall_now,
   input  logic                                 req_key_pause,
   input  logic                                 req_key_resume,
   input  logic                                 req_key_forward,
   input  logic                                 req_key_rewind,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fcs_pkg::SCENE_W-1:0]          rsp_scene_time,
   output logic signed [fcs_pkg::DELTA_W-1:0]   rsp_frame_delta,
   output logic signed [fcs_pkg::FINE_W-1:0]    rsp_fine_time,
   output logic                                 rsp_override_coarse,
   output logic                                 rsp_paused,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fcs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fcs_pkg::CSR_DATA_W-1:0]       csr_data
);

   // Control registers. Writes are always taken.
   logic [fcs_pkg::CSR_DATA_W-1:0] wall_freq_ff;
   logic                           fine_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_freq_ff   <= fcs_pkg::WALL_FREQ_RST;
         fine_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == fcs_pkg::CSR_WALL_FREQ)
            wall_freq_ff <= csr_data;
         else if (csr_index == fcs_pkg::CSR_FINE_ENABLE)
            fine_enable_ff <= csr_data[0];
      end
   end

   assign csr_ready = 1'b1;

   fcs_pkg::fcs_cmd_type    cmd;
   fcs_pkg::fcs_status_type status;
   logic                    rsp_valid_ff;
   logic                    rsp_free;

   // The output register can be reloaded in the same cycle its item leaves.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_free  (rsp_free),
      .status    (status),
      .cmd       (cmd)
   );

   logic [fcs_pkg::SCENE_W-1:0]        res_scene_time;
   logic signed [fcs_pkg::DELTA_W-1:0] res_frame_delta;
   logic signed [fcs_pkg::FINE_W-1:0]  res_fine_time;
   logic                               res_override_coarse;
   logic                               res_paused;

   fcs_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .wall_freq           (wall_freq_ff),
      .fine_enable         (fine_enable_ff),
      .req_coarse_now      (req_coarse_now),
      .req_wall_now        (req_wall_now),
      .req_key_pause       (req_key_pause),
      .req_key_resume      (req_key_resume),
      .req_key_forward     (req_key_forward),
      .req_key_rewind      (req_key_rewind),
      .res_scene_time      (res_scene_time),
      .res_frame_delta     (res_frame_delta),
      .res_fine_time       (res_fine_time),
      .res_override_coarse (res_override_coarse),
      .res_paused          (res_paused)
   );

   // Output register.
   logic [fcs_pkg::SCENE_W-1:0]        scene_ff;
   logic signed [fcs_pkg::DELTA_W-1:0] delta_ff;
   logic signed [fcs_pkg::FINE_W-1:0]  fine_ff;
   logic                               override_ff;
   logic                               paused_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         scene_ff    <= res_scene_time;
         delta_ff    <= res_frame_delta;
         fine_ff     <= res_fine_time;
         override_ff <= res_override_coarse;
         paused_ff   <= res_paused;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scene_time      = scene_ff;
   assign rsp_frame_delta     = delta_ff;
   assign rsp_fine_time       = fine_ff;
   assign rsp_override_coarse = override_ff;
   assign rsp_paused          = paused_ff;

endmodule

FILE: tb/frame_clock_smoother_top_tb.sv
module frame_clock_smoother_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fcs_pkg::*;

   // One frame as presented on the request channel.
   typedef struct {
      logic [SCENE_W-1:0] coarse;
      logic [WALL_W-1:0]  wall;
      logic               pause;
      logic               resume;
      logic               fwd;
      logic               rew;
   } frame_in_type;

   // One frame result as returned on the response channel.
   typedef struct {
      logic [SCENE_W-1:0]        scene;
      logic signed [DELTA_W-1:0] delta;
      logic signed [FINE_W-1:0]  fine;
      logic                      override_q;
      logic                      paused_q;
   } frame_result_type;

   // A row of the directed table. When typed is set, the row carries its own
   // expected result, which must agree with the predictor as well.
   typedef struct {
      frame_in_type     frame;
      bit               typed;
      frame_result_type result;
   } directed_row_type;

   localparam int  HALF_PERIOD   = 10;
   localparam int  CYCLE_LIMIT   = 1500000;
   localparam int  SETTLE_CYCLES = 200;
   localparam int  RANDOM_ITEMS  = 1080;
   localparam int  NUM_PHASES    = 6;
   localparam int  LONG_HOLD     = 600;
   localparam longint ALPHA_Q16  = 3277;
   localparam longint SOFT_Q16   = 655;
   localparam longint FIRM_Q16   = 6554;
   localparam longint RATE_LO    = 13107;
   localparam longint RATE_HI    = 196608;
   localparam longint ONE_Q16    = 65536;
   localparam longint SCENE_TOP  = 64'd2147483647;
   localparam int  FB            = FRAC_BITS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [SCENE_W-1:0]          req_coarse_now = '0;
   logic [WALL_W-1:0]           req_wall_now = '0;
   logic                        req_key_pause = 1'b0;
   logic                        req_key_resume = 1'b0;
   logic                        req_key_forward = 1'b0;
   logic                        req_key_rewind = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [SCENE_W-1:0]          rsp_scene_time;
   logic signed [DELTA_W-1:0]   rsp_frame_delta;
   logic signed [FINE_W-1:0]    rsp_fine_time;
   logic                        rsp_override_coarse;
   logic                        rsp_paused;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_WALL_FREQ;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   frame_clock_smoother_top DUT (.*);

   // The clock toggles every half period for the whole run.
   always #HALF_PERIOD clock = ~clock;

   // Predictor copy of the block's registers and frame state.
   logic [31:0]        wall_freq_q;
   logic               fine_enable_q;
   logic [SCENE_W-1:0] prev_scene_q;
   logic               pause_q;
   logic [FINE_W-1:0]  fine_clock_q;
   logic [31:0]        coarse_avg_q;
   logic [31:0]        wall_avg_q;
   logic [WALL_W-1:0]  prev_wall_q;
   logic [SCENE_W-1:0] last_scene_q;

   // Results that the block still owes us, oldest first.
   frame_result_type pending_frames[$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               hold_requests = 0;

   // Exponential moving average with a 0.05 weight, clamped to 32 bits.
   function automatic logic [31:0] ema_step(input logic [31:0] avg, input longint x);
      longint a;
      longint r;
      a = avg;
      r = a + (((x - a) * ALPHA_Q16) >>> 16);
      if (r < 0) r = 0;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      return r[31:0];
   endfunction

   // Works out one frame and advances the predictor state.
   function automatic frame_result_type smooth_frame(input frame_in_type f);
      frame_result_type res;
      longint now, delta, step, st, fine, dtim, dw, rate, off, target, coef;
      longint unsigned freq, diff;
      logic signed [FINE_W-1:0] fc;
      bit scrub;
      bit ok;
      now = f.coarse;
      delta = now - longint'(prev_scene_q);
      scrub = 1'b0;
      if (delta > 300) delta = 300;
      if (f.pause) pause_q = 1'b1;
      if (f.resume) pause_q = 1'b0;
      st = pause_q ? longint'(prev_scene_q) : now;
      step = pause_q ? 10 : delta * 8;
      if (f.fwd) begin
         st = st + step;
         scrub = 1'b1;
      end
      if (f.rew) begin
         st = (step > st) ? 0 : st - step;
         scrub = 1'b1;
      end
      if (st < 0) st = 0;
      if (st > SCENE_TOP) st = SCENE_TOP;

      fc = fine_clock_q;
      fine = fc;
      if (fine_enable_q && !pause_q && !scrub && fine >= 0 && prev_wall_q != 0) begin
         freq = (wall_freq_q != 0) ? longint'(wall_freq_q) : 1;
         diff = f.wall - prev_wall_q;
         dtim = st - longint'(last_scene_q);
         ok = diff != 0 && diff <= 64'hFFFF_FFFF && diff * 100 <= 60 * freq
              && dtim >= 0 && dtim <= 60;
         if (ok) begin
            dw = ((diff * 100) << FB) / freq;
            coarse_avg_q = ema_step(coarse_avg_q, dtim << FB);
            wall_avg_q = ema_step(wall_avg_q, dw);
            if (wall_avg_q > ((1 << FB) / 1000))
               rate = (longint'(coarse_avg_q) << 16) / longint'(wall_avg_q);
            else
               rate = ONE_Q16;
            if (rate < RATE_LO) rate = RATE_LO;
            if (rate > RATE_HI) rate = RATE_HI;
            fine = fine + ((dw * rate) >>> 16);
            target = st << FB;
            off = target - fine;
            if (off > (120 << FB) || off < -(120 <<< FB)) begin
               fine = target;
            end else begin
               coef = (off > (8 << FB) || off < -(8 <<< FB)) ? FIRM_Q16 : SOFT_Q16;
               fine = fine + ((off * coef) >>> 16);
            end
         end else if (dtim > 0) begin
            fine = fine + (dtim << FB);
         end
      end else begin
         fine = st << FB;
      end
      fine_clock_q = fine[FINE_W-1:0];
      prev_wall_q = f.wall;
      last_scene_q = st[SCENE_W-1:0];
      prev_scene_q = st[SCENE_W-1:0];

      res.scene = st[SCENE_W-1:0];
      res.delta = delta[DELTA_W-1:0];
      res.fine = fine_clock_q;
      res.override_q = pause_q | scrub;
      res.paused_q = pause_q;
      return res;
   endfunction

   // True when two results agree in every field.
   function automatic bit same_result(input frame_result_type a, input frame_result_type b);
      return a.scene == b.scene && a.delta == b.delta && a.fine == b.fine
             && a.override_q == b.override_q && a.paused_q == b.paused_q;
   endfunction

   // Offers one frame and holds it until the block takes it. The expected
   // result is queued at the accepting edge.
   task automatic send_frame(input frame_in_type f, input bit typed,
                             input frame_result_type typed_res,
                             output frame_result_type predicted);
      req_coarse_now <= f.coarse;
      req_wall_now <= f.wall;
      req_key_pause <= f.pause;
      req_key_resume <= f.resume;
      req_key_forward <= f.fwd;
      req_key_rewind <= f.rew;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = smooth_frame(f);
      if (typed && !same_result(predicted, typed_res)) begin
         $error("directed row: expected scene %0d delta %0d fine %0h, predictor %0d %0d %0h",
                typed_res.scene, typed_res.delta, typed_res.fine,
                predicted.scene, predicted.delta, predicted.fine);
         error_count++;
      end
      pending_frames.push_back(typed ? typed_res : predicted);
   endtask

   // Drops valid for a number of cycles between bursts.
   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Writes one control register while the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_WALL_FREQ) wall_freq_q = val;
      else if (idx == CSR_FINE_ENABLE) fine_enable_q = val[0];
      @(posedge clock);
   endtask

   // Waits until every expected result is back and the block has had time to
   // finish any frame still in flight.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The receiver alternates between always-ready stretches and a stall
   // pattern of its own, and honors a long hold-off whenever one is asked for.
   int  hold_left = 0;
   int  holds_seen = 0;
   int  ready_phase = 0;
   bit  stall_mode = 1'b0;
   always @(posedge clock) begin
      ready_phase <= ready_phase + 1;
      if (ready_phase % 300 == 0) stall_mode <= $urandom_range(0, 2) != 0;
      if (hold_requests != holds_seen) begin
         holds_seen <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_mode) begin
         rsp_ready <= (ready_phase % 7 < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every accepted result is compared against the oldest expectation.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected result: scene_time %0d", rsp_scene_time);
            error_count++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_scene_time !== want.scene) begin
               $error("scene_time: expected %0d, got %0d", want.scene, rsp_scene_time);
               error_count++;
            end
            if (rsp_frame_delta !== want.delta) begin
               $error("frame_delta: expected %0d, got %0d", want.delta, rsp_frame_delta);
               error_count++;
            end
            if (rsp_fine_time !== want.fine) begin
               $error("fine_time: expected %0h, got %0h", want.fine, rsp_fine_time);
               error_count++;
            end
            if (rsp_override_coarse !== want.override_q) begin
               $error("override_coarse: expected %0b, got %0b",
                      want.override_q, rsp_override_coarse);
               error_count++;
            end
            if (rsp_paused !== want.paused_q) begin
               $error("paused: expected %0b, got %0b", want.paused_q, rsp_paused);
               error_count++;
            end
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Builds a row of the directed table.
   function automatic directed_row_type row(input logic [SCENE_W-1:0] c,
                                            input logic [WALL_W-1:0] w,
                                            input logic [3:0] keys);
      directed_row_type r;
      r.frame.coarse = c;
      r.frame.wall = w;
      {r.frame.pause, r.frame.resume, r.frame.fwd, r.frame.rew} = keys;
      r.typed = 1'b0;
      r.result = '{default: '0};
      return r;
   endfunction

   localparam logic [3:0] NO_KEY = 4'b0000;
   localparam logic [3:0] K_PAUSE = 4'b1000;
   localparam logic [3:0] K_RESUME = 4'b0100;
   localparam logic [3:0] K_FWD = 4'b0010;
   localparam logic [3:0] K_REW = 4'b0001;

   initial begin
      directed_row_type table_rows[$];
      directed_row_type r;
      frame_in_type     f;
      frame_result_type got;
      logic [31:0]   phase_freq[NUM_PHASES];
      bit            phase_enable[NUM_PHASES];
      logic [SCENE_W-1:0] sim_coarse;
      logic [WALL_W-1:0]  sim_wall;
      longint unsigned    tick_wall, wall_step;
      int ticks, burst_left, per_phase;

      // Predictor state after reset.
      wall_freq_q = WALL_FREQ_RST;
      fine_enable_q = 1'b1;
      prev_scene_q = '0;
      pause_q = 1'b0;
      fine_clock_q = '1;
      coarse_avg_q = '0;
      wall_avg_q = '0;
      prev_wall_q = '0;
      last_scene_q = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The first frames after reset have results that can be
      // read off directly: the fine clock is invalid and simply seeds from the
      // scene time, the top coarse value caps the delta, and the pause key
      // freezes scene time while asking for the coarse counter to be reloaded.
      r = row(31'd0, 64'd0, NO_KEY);
      r.typed = 1'b1;
      r.result = '{scene: 31'd0, delta: 32'sd0, fine: 48'sd0, override_q: 1'b0, paused_q: 1'b0};
      table_rows.push_back(r);
      r = row(31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, NO_KEY);
      r.typed = 1'b1;
      r.result = '{scene: 31'h7FFF_FFFF, delta: 32'sd300, fine: 48'sh7FFF_FFFF_0000,
                   override_q: 1'b0, paused_q: 1'b0};
      table_rows.push_back(r);
      r = row(31'd5, 64'd1, K_PAUSE);
      r.typed = 1'b1;
      r.result = '{scene: 31'h7FFF_FFFF, delta: -32'sd2147483642, fine: 48'sh7FFF_FFFF_0000,
                   override_q: 1'b1, paused_q: 1'b1};
      table_rows.push_back(r);
      // Forward while paused saturates at the top of the scene range.
      table_rows.push_back(row(31'd6, 64'd2, K_FWD));
      table_rows.push_back(row(31'd7, 64'd3, K_REW));
      // Both pause and resume held: resume wins.
      table_rows.push_back(row(31'd100, 64'd4, K_PAUSE | K_RESUME));
      // Rewind in play by eight times a negative delta, then both scrub keys together.
      table_rows.push_back(row(31'd50, 64'd10000000, K_REW));
      table_rows.push_back(row(31'd10, 64'd20000000, K_FWD | K_REW));
      // Wall counter of zero marks the next frame as having no prior sample.
      table_rows.push_back(row(31'd100, 64'd0, NO_KEY));
      table_rows.push_back(row(31'd101, 64'd10000000, NO_KEY));
      // Well-formed frames that take the smoothing path.
      table_rows.push_back(row(31'd102, 64'd20000000, NO_KEY));
      table_rows.push_back(row(31'd103, 64'd30100000, NO_KEY));
      table_rows.push_back(row(31'd105, 64'd50000000, NO_KEY));
      // Hitches: no wall movement, a wall step beyond 60 cs, a coarse jump.
      table_rows.push_back(row(31'd106, 64'd50000000, NO_KEY));
      table_rows.push_back(row(31'd107, 64'd900000000, NO_KEY));
      table_rows.push_back(row(31'd200, 64'd910000000, NO_KEY));
      // Large offset: the scene jumps back while the wall step is normal.
      table_rows.push_back(row(31'd201, 64'd920000000, NO_KEY));
      table_rows.push_back(row(31'd60, 64'd930000000, NO_KEY));
      table_rows.push_back(row(31'd61, 64'd940000000, NO_KEY));
      // Near the top of the scene range the fine clock can wrap.
      table_rows.push_back(row(31'h7FFF_FFF0, 64'd950000000, NO_KEY));
      table_rows.push_back(row(31'h7FFF_FFFF, 64'd1400000000, NO_KEY));
      table_rows.push_back(row(31'h7FFF_FFFF, 64'd1800000000, NO_KEY));
      table_rows.push_back(row(31'h7FFF_FFFF, 64'd1810000000, NO_KEY));
      table_rows.push_back(row(31'd0, 64'h8000_0000_0000_0000, K_PAUSE | K_FWD | K_REW));

      foreach (table_rows[i])
         send_frame(table_rows[i].frame, table_rows[i].typed, table_rows[i].result, got);

      // Random part. Each phase runs with its own register setting, the
      // extremes of the wall frequency among them, and both fine clock modes.
      phase_freq = '{32'd1000000000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd48000, 32'd1000000000};
      phase_enable = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      per_phase = RANDOM_ITEMS / NUM_PHASES;
      sim_coarse = got.scene;
      sim_wall = table_rows[table_rows.size()-1].frame.wall;
      burst_left = 0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_and_settle();
         write_reg(CSR_WALL_FREQ, phase_freq[p]);
         write_reg(CSR_FINE_ENABLE, {31'd0, phase_enable[p]});
         tick_wall = (phase_freq[p] == 0) ? 0 : longint'(phase_freq[p]) / 100;

         for (int n = 0; n < per_phase; n++) begin
            // Phase one fills the block with the receiver held off; phase
            // two pauses the sender until every result has come back.
            if (p == 1 && n == 20) hold_requests++;
            if (p == 2 && n == 50) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_frames.size() != 0);
            end

            if ($urandom_range(0, 9) == 0) begin
               // Noise: every field takes arbitrary values.
               f.coarse = SCENE_W'($urandom());
               f.wall = {$urandom(), $urandom()};
               {f.pause, f.resume, f.fwd, f.rew} = 4'($urandom_range(0, 15));
            end else begin
               // A well-formed frame: coarse ticks follow the wall counter,
               // with a little jitter and occasional keys.
               ticks = $urandom_range(0, 4);
               wall_step = ticks * tick_wall + $urandom_range(0, 32'(tick_wall / 10 + 1));
               if ($urandom_range(0, 30) == 0) wall_step = 0;
               f.coarse = SCENE_W'(sim_coarse + ticks);
               f.wall = sim_wall + wall_step;
               f.pause = $urandom_range(0, 19) == 0;
               f.resume = $urandom_range(0, 9) == 0;
               f.fwd = $urandom_range(0, 24) == 0;
               f.rew = $urandom_range(0, 24) == 0;
            end
            send_frame(f, 1'b0, '{default: '0}, got);
            // An overriding frame reloads the coarse counter with scene time.
            sim_coarse = got.scene;
            sim_wall = f.wall;

            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (!(p == 1 && n >= 20 && n < 60))
                  sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150));
            end else begin
               burst_left--;
            end
         end
      end

      // Wait for the last results, then give the block time to go quiet.
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/fcs_pkg.sv
sv/fcs_divider.sv
sv/fcs_datapath.sv
sv/fcs_ctrl.sv
sv/frame_clock_smoother_top.sv
tb/frame_clock_smoother_top_tb.sv
